// ===== rtl/core/cacc_pkg.sv =====
package cacc_pkg;

   // Field widths
   localparam int SAMPLE_W  = 10;
   localparam int MS_W      = 16;
   localparam int CUR_W     = 19;
   localparam int PEAK_W    = 18;
   localparam int CHARGE_W  = 48;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 104;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Largest current magnitude: 1023 * 255
   localparam int CUR_MAX = 260865;

   localparam int WINDOW_DEF = 25;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND    = 2'd2;

   localparam logic [9:0]  ZERO_OFFSET_RST = 10'd526;
   localparam logic [7:0]  GAIN_RST        = 8'd125;
   localparam logic [15:0] DEADBAND_RST    = 16'd154;

   typedef logic signed [CUR_W-1:0] cur_type;

endpackage

// ===== rtl/core/cacc_mul.sv =====
module cacc_mul
   import cacc_pkg::*;
#(
   parameter int A_W = 24,
   parameter int B_W = 26
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] p
);

   logic signed [A_W+B_W-1:0] p_ff;

   // Product register; holds while not enabled
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= a * b;
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/core/current_average_and_charge_counter.sv =====
// An accepted req steps through MULCUR, DBAND, TOTAL, CHARGE and AVG; AVG sets
// rsp_tvalid once the output register is free. req_tready is high only in IDLE;
// the single shared multiplier makes three passes per item (gain, charge product, reciprocal for the average).
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, active high) restores the register defaults and clears
// the window valid bits, window total, slot, peak and charge; no clearing pass.
module current_average_and_charge_counter
   import cacc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [9:0] sample, [25:10] elapsed_ms, [31:26] zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // rsp_tdata: [18:0] instant_current, [37:19] average_current,
   //            [55:38] peak_current, [103:56] charge
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // Configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);

   // Window sizing. TOT_N bits hold the largest window total magnitude.
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TOT_N  = $clog2(WINDOW * CUR_MAX + 1);
   localparam int TOT_W  = TOT_N + 1;
   // Exact divide by WINDOW: floor(x/W) = (x * RECIP) >> SHIFT for x < 2**TOT_N
   localparam int LOG_W  = $clog2(WINDOW);
   localparam int SHIFT  = TOT_N + LOG_W;
   localparam int RW     = TOT_N + 2;
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   // Shared multiplier operand widths
   localparam int MA = (CUR_W > TOT_N + 1) ? CUR_W : TOT_N + 1;
   localparam int MB = (MS_W + 1 > RW + 1) ? MS_W + 1 : RW + 1;
   localparam int PW = MA + MB;

   // Sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MULCUR = 3'd1;
   localparam logic [2:0] ST_DBAND  = 3'd2;
   localparam logic [2:0] ST_TOTAL  = 3'd3;
   localparam logic [2:0] ST_CHARGE = 3'd4;
   localparam logic [2:0] ST_AVG    = 3'd5;

   logic [2:0]              state_ff, state_in;

   // Configuration registers
   logic [9:0]              zero_offset_ff;
   logic [7:0]              gain_ff;
   logic [15:0]             deadband_ff;

   // Item registers
   logic [SAMPLE_W-1:0]     sample_ff;
   logic [MS_W-1:0]         ms_ff;
   cur_type                 cur_ff, cur_in;

   // Window ring
   cur_type                 win_mem [WINDOW];
   cur_type                 mem_rd_ff;
   logic [WINDOW-1:0]       vld_ff;
   logic                    vld_rd_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic signed [TOT_W-1:0] total_ff, total_in;

   logic [PEAK_W-1:0]       peak_ff;
   logic signed [CHARGE_W-1:0] charge_ff, charge_in;

   // Output register
   logic                    rsp_valid_ff;
   cur_type                 out_cur_ff, out_avg_ff;
   logic [PEAK_W-1:0]       out_peak_ff;
   logic signed [CHARGE_W-1:0] out_charge_ff;

   // Shared multiplier
   logic                    mul_en;
   logic signed [MA-1:0]    mul_a;
   logic signed [MB-1:0]    mul_b;
   logic signed [PW-1:0]    mul_p;

   logic                    req_fire;
   logic                    out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;

   // Sequencer: the AVG step waits for the output register to free up
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_MULCUR;
         ST_MULCUR: state_in = ST_DBAND;
         ST_DBAND:  state_in = ST_TOTAL;
         ST_TOTAL:  state_in = ST_CHARGE;
         ST_CHARGE: state_in = ST_AVG;
         ST_AVG:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Operand select for the shared multiplier
   logic signed [SAMPLE_W:0] diff;
   logic signed [TOT_W-1:0]  tot_abs;

   assign diff    = $signed({1'b0, sample_ff}) - $signed({1'b0, zero_offset_ff});
   assign tot_abs = total_ff[TOT_W-1] ? -total_ff : total_ff;

   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_MULCUR: begin
            mul_en = 1'b1;
            mul_a  = MA'(diff);
            mul_b  = MB'($signed({1'b0, gain_ff}));
         end
         ST_TOTAL: begin
            mul_en = 1'b1;
            mul_a  = MA'(cur_ff);
            mul_b  = MB'($signed({1'b0, ms_ff}));
         end
         ST_CHARGE: begin
            // total_ff already holds the new window total here
            mul_en = 1'b1;
            mul_a  = MA'($signed({1'b0, tot_abs[TOT_N-1:0]}));
            mul_b  = MB'($signed({1'b0, RECIP[RW-1:0]}));
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   cacc_mul #(
      .A_W (MA),
      .B_W (MB)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   // Deadband on the fresh product
   cur_type           cur_raw;
   logic [CUR_W-1:0]  cur_mag;

   assign cur_raw = mul_p[CUR_W-1:0];
   assign cur_mag = cur_raw[CUR_W-1] ? CUR_W'(-cur_raw) : CUR_W'(cur_raw);
   assign cur_in  = (cur_mag < {3'b000, deadband_ff}) ? '0 : cur_raw;

   // Running total: drop the leaving entry, add the new one
   cur_type old_val;

   assign old_val  = vld_rd_ff ? mem_rd_ff : '0;
   assign total_in = total_ff - TOT_W'(old_val) + TOT_W'(cur_ff);

   // Charge accumulate with clamp to the 48-bit signed range
   logic signed [CHARGE_W:0] charge_sum;

   assign charge_sum = {charge_ff[CHARGE_W-1], charge_ff} + (CHARGE_W+1)'(mul_p);
   always_comb begin
      if (charge_sum[CHARGE_W] != charge_sum[CHARGE_W-1]) begin
         charge_in = charge_sum[CHARGE_W] ? {1'b1, {(CHARGE_W-1){1'b0}}}
                                          : {1'b0, {(CHARGE_W-1){1'b1}}};
      end else begin
         charge_in = charge_sum[CHARGE_W-1:0];
      end
   end

   // Average: reciprocal product shifted down, sign restored (truncates to zero)
   logic signed [PW-1:0] p_shift;
   logic [CUR_W-1:0]     avg_mag;
   cur_type              avg_val;
   logic                 peak_up;

   assign p_shift = mul_p >>> SHIFT;
   assign avg_mag = p_shift[CUR_W-1:0];
   assign avg_val = total_ff[TOT_W-1] ? -$signed(avg_mag) : $signed(avg_mag);
   assign peak_up = avg_val > $signed({1'b0, peak_ff});

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         zero_offset_ff <= ZERO_OFFSET_RST;
         gain_ff        <= GAIN_RST;
         deadband_ff    <= DEADBAND_RST;
         vld_ff         <= '0;
         slot_ff        <= '0;
         total_ff       <= '0;
         peak_ff        <= '0;
         charge_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ZERO_OFFSET: zero_offset_ff <= csr_data[9:0];
               REG_GAIN:        gain_ff        <= csr_data[7:0];
               REG_DEADBAND:    deadband_ff    <= csr_data;
               default:         ;
            endcase
         end
         if (state_ff == ST_TOTAL) begin
            vld_ff[slot_ff] <= 1'b1;
            total_ff        <= total_in;
            slot_ff         <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         end
         if (state_ff == ST_CHARGE) begin
            charge_ff <= charge_in;
         end
         if (state_ff == ST_AVG && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (peak_up) begin
               peak_ff <= avg_mag[PEAK_W-1:0];
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_tdata[SAMPLE_W-1:0];
         ms_ff     <= req_tdata[SAMPLE_W+MS_W-1:SAMPLE_W];
      end
      if (state_ff == ST_DBAND) begin
         cur_ff <= cur_in;
      end
      if (state_ff == ST_AVG && out_free) begin
         out_cur_ff    <= cur_ff;
         out_avg_ff    <= avg_val;
         out_peak_ff   <= peak_up ? avg_mag[PEAK_W-1:0] : peak_ff;
         out_charge_ff <= charge_ff;
      end
   end

   // Window memory, registered read at the current slot
   always_ff @(posedge clock) begin
      if (state_ff == ST_TOTAL) begin
         win_mem[slot_ff] <= cur_ff;
      end
      mem_rd_ff <= win_mem[slot_ff];
      vld_rd_ff <= vld_ff[slot_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_charge_ff, out_peak_ff, out_avg_ff, out_cur_ff};

endmodule

// ===== rtl/core/cacc_chk.sv =====
module cacc_chk
   import cacc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata
);

   logic [CUR_W-1:0]  avg;
   logic [PEAK_W-1:0] peak;

   assign avg  = rsp_tdata[37:19];
   assign peak = rsp_tdata[55:38];

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // One item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while busy");

   // Peak is never below a non-negative average
   a_peak_ge_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !avg[CUR_W-1] |-> peak >= avg[PEAK_W-1:0])
      else $error("peak below average");

   // No result straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind current_average_and_charge_counter cacc_chk u_cacc_chk (.*);

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cacc_pkg::*;

   // ------------------------------------------------------------------
   // Run shape
   // ------------------------------------------------------------------
   localparam int CYCLE_LIMIT   = 3_000_000;  // watchdog, far above a slow correct run
   localparam int SETTLE_CYCLES = 8;          // pipeline latency plus margin
   localparam int TAIL_CYCLES   = 20;         // quiet time after the last result
   localparam int LONG_HOLDOFF  = 300;        // long receiver stall, in cycles
   localparam int RAND_PHASES   = 8;
   localparam int RAND_ITEMS    = 206;        // per random phase

   // Index 3 decodes to no register; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 2'd3;

   localparam longint CHARGE_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint CHARGE_LO = -CHARGE_HI - 64'sd1;

   // Result layout, msb first, so it maps straight onto rsp_tdata
   typedef struct packed {
      logic signed [CHARGE_W-1:0] charge;
      logic        [PEAK_W-1:0]   peak;
      logic signed [CUR_W-1:0]    average;
      logic signed [CUR_W-1:0]    instant;
   } reading_type;

   typedef enum logic {STEP_ADC, STEP_CSR} step_kind_type;

   // One row of the directed table: either a register write or a sample
   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] value;
      logic [SAMPLE_W-1:0]  adc;
      logic [MS_W-1:0]      ms;
      bit                   fixed;   // expectation typed in below
      reading_type          want;
   } step_type;

   // ------------------------------------------------------------------
   // DUT signals
   // ------------------------------------------------------------------
   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   current_average_and_charge_counter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the block: registers, window ring, peak and charge
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0] zero_offset_q = ZERO_OFFSET_RST;
   logic [7:0]          gain_q        = GAIN_RST;
   logic [15:0]         deadband_q    = DEADBAND_RST;

   int     ring [WINDOW_DEF] = '{default: 0};
   int     ring_slot  = 0;
   longint ring_total = 0;
   longint peak_q     = 0;
   longint charge_q   = 0;

   reading_type expected_readings[$];
   step_type    directed_steps[$];

   // Bookkeeping
   int     items_sent      = 0;
   int     csr_writes      = 0;
   int     readings_seen   = 0;
   int     mismatch_count  = 0;
   int     settings_run    = 0;
   longint cycle_count     = 0;
   int     tx_burst_left   = 0;   // sender only
   int     holdoff_requests = 0;  // sender only
   int     holdoffs_served  = 0;  // receiver only

   // Convert one sample, push it through the window and integrate charge.
   function automatic reading_type charge_step(logic [SAMPLE_W-1:0] adc, logic [MS_W-1:0] ms);
      int          cur;
      int          mag;
      longint      avg;
      longint      sum;
      reading_type r;
      cur = (int'(adc) - int'(zero_offset_q)) * int'(gain_q);
      mag = (cur < 0) ? -cur : cur;
      if (mag < int'(deadband_q)) cur = 0;
      ring_total -= ring[ring_slot];
      ring[ring_slot] = cur;
      ring_total += cur;
      ring_slot = (ring_slot == WINDOW_DEF - 1) ? 0 : ring_slot + 1;
      avg = ring_total / WINDOW_DEF;     // signed divide truncates toward zero
      if (avg > peak_q) peak_q = avg;    // negative averages never move the peak
      sum = charge_q + longint'(cur) * longint'(ms);
      if (sum > CHARGE_HI) sum = CHARGE_HI;
      if (sum < CHARGE_LO) sum = CHARGE_LO;
      charge_q  = sum;
      r.instant = cur[CUR_W-1:0];
      r.average = avg[CUR_W-1:0];
      r.peak    = peak_q[PEAK_W-1:0];
      r.charge  = charge_q[CHARGE_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock, watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_readings.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result checking: every rsp transaction against the oldest expectation
   // ------------------------------------------------------------------
   function automatic void check_reading(reading_type got);
      reading_type want;
      readings_seen++;
      if (expected_readings.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result %0d: instant %0d average %0d peak %0d charge %0d",
                     readings_seen, got.instant, got.average, got.peak, got.charge);
         return;
      end
      want = expected_readings.pop_front();
      if (got.instant !== want.instant || got.average !== want.average ||
          got.peak !== want.peak || got.charge !== want.charge) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch on result %0d:", readings_seen);
            $display("  instant exp %0d got %0d, average exp %0d got %0d",
                     want.instant, got.instant, want.average, got.average);
            $display("  peak exp %0d got %0d, charge exp %0d got %0d",
                     want.peak, got.peak, want.charge, got.charge);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         check_reading(reading_type'(rsp_tdata));
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, steady stretches, and long hold-offs on demand
   // ------------------------------------------------------------------
   initial begin : rsp_sink
      int   stall_left;
      int   steady_left;
      int   r;
      logic ready_nxt;
      stall_left  = 0;
      steady_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_requests > holdoffs_served) begin
            holdoffs_served++;
            stall_left  = LONG_HOLDOFF;
            steady_left = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_nxt = 1'b0;
         end else if (steady_left > 0) begin
            steady_left--;
            ready_nxt = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            ready_nxt = 1'b1;
            if (r >= 96) begin
               steady_left = $urandom_range(20, 120);
            end else if (r >= 90) begin
               stall_left = $urandom_range(10, 60);
               ready_nxt  = 1'b0;
            end else if (r >= 62) begin
               stall_left = $urandom_range(0, 2);
               ready_nxt  = 1'b0;
            end
         end
         rsp_tready <= ready_nxt;
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // Gap before the next req transaction: mostly none or short, a few long,
   // and now and then a gapless burst.
   function automatic int sender_gap();
      int r;
      if (tx_burst_left > 0) begin
         tx_burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 12);
      if (r < 96) begin
         tx_burst_left = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(25, 70);
   endfunction

   // Offer one sample; predict and queue its result once it is taken.
   task automatic send_reading(input logic [SAMPLE_W-1:0] adc, input logic [MS_W-1:0] ms,
                               input bit fixed, input reading_type want);
      int          gap;
      reading_type pred;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - SAMPLE_W - MS_W){1'b0}}, ms, adc};
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = charge_step(adc, ms);
      expected_readings.push_back(fixed ? want : pred);
      items_sent++;
   endtask

   // Stop offering, let every result drain, then let the pipeline settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      // bits above each register's width are dropped
      case (idx)
         REG_ZERO_OFFSET: zero_offset_q = value[SAMPLE_W-1:0];
         REG_GAIN:        gain_q        = value[7:0];
         REG_DEADBAND:    deadband_q    = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   // Directed table builders
   task automatic add_adc(input logic [SAMPLE_W-1:0] adc, input logic [MS_W-1:0] ms);
      step_type s;
      s = '{kind: STEP_ADC, index: '0, value: '0, adc: adc, ms: ms, fixed: 1'b0, want: '0};
      directed_steps.push_back(s);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      step_type s;
      s = '{kind: STEP_CSR, index: idx, value: value, adc: '0, ms: '0, fixed: 1'b0, want: '0};
      directed_steps.push_back(s);
   endtask

   task automatic add_fixed(input logic [SAMPLE_W-1:0] adc, input logic [MS_W-1:0] ms,
                            input longint inst, input longint avg, input longint pk,
                            input longint chg);
      step_type s;
      s = '{kind: STEP_ADC, index: '0, value: '0, adc: adc, ms: ms, fixed: 1'b1, want: '0};
      s.want.instant = inst[CUR_W-1:0];
      s.want.average = avg[CUR_W-1:0];
      s.want.peak    = pk[PEAK_W-1:0];
      s.want.charge  = chg[CHARGE_W-1:0];
      directed_steps.push_back(s);
   endtask

   // One random setting: all three registers, sometimes a write to the
   // unused index, then a run of samples biased toward the zero offset and the ADC ends.
   task automatic random_phase(input int n_items, input bit holdoff);
      int                  k;
      int                  r;
      int                  near;
      logic [SAMPLE_W-1:0] zo;
      logic [7:0]          g;
      logic [15:0]         db;
      logic [SAMPLE_W-1:0] adc;
      logic [MS_W-1:0]     ms;
      case ($urandom_range(0, 3))
         0:       zo = '0;
         1:       zo = '1;
         2:       zo = ZERO_OFFSET_RST;
         default: zo = SAMPLE_W'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 3))
         0:       g = '0;
         1:       g = '1;
         2:       g = GAIN_RST;
         default: g = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 4))
         0:       db = '0;
         1:       db = '1;
         2:       db = DEADBAND_RST;
         3:       db = 16'($urandom_range(0, 65535));
         default: db = 16'($urandom_range(0, 4000));
      endcase
      // junk in the unused upper bits must not leak into the registers
      write_csr(REG_ZERO_OFFSET, (16'($urandom) & 16'hFC00) | 16'(zo));
      write_csr(REG_GAIN, (16'($urandom) & 16'hFF00) | 16'(g));
      write_csr(REG_DEADBAND, db);
      if ($urandom_range(0, 1) == 1) write_csr(REG_NONE, 16'($urandom));
      settings_run++;

      if (holdoff) begin
         // receiver freezes while we keep pushing: the block backs up
         holdoff_requests++;
         tx_burst_left = 24;
      end

      for (k = 0; k < n_items; k++) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            adc = SAMPLE_W'($urandom_range(0, 1023));
         end else if (r < 85) begin
            near = int'(zero_offset_q) + int'($urandom_range(0, 16)) - 8;
            if (near < 0) near = 0;
            if (near > 1023) near = 1023;
            adc = near[SAMPLE_W-1:0];
         end else begin
            adc = ($urandom_range(0, 1) == 1) ? '1 : '0;
         end
         r = $urandom_range(0, 99);
         if (r < 50)      ms = MS_W'($urandom_range(0, 50));
         else if (r < 80) ms = MS_W'($urandom_range(0, 65535));
         else if (r < 90) ms = '0;
         else             ms = '1;
         send_reading(adc, ms, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int p;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;

      // Directed table, reset register values first
      add_fixed(10'd526, 16'd0, 0, 0, 0, 0);                      // zero current
      add_fixed(10'd1023, 16'hFFFF, 62125, 2485, 2485, 64'd4071361875);
      add_adc(10'd0, 16'hFFFF);                                   // negative, peak holds
      add_adc(10'd527, 16'd100);                                  // +125 below deadband
      add_adc(10'd525, 16'd100);                                  // -125 below deadband
      add_adc(10'd528, 16'd7);                                    // +250 passes
      add_csr(REG_DEADBAND, 16'd250);
      add_adc(10'd528, 16'd1);                                    // magnitude equals deadband
      add_adc(10'd524, 16'd1);
      add_csr(REG_DEADBAND, 16'd251);
      add_adc(10'd528, 16'd3);                                    // one below deadband
      add_csr(REG_NONE, 16'hFFFF);                                // must change nothing
      add_adc(10'd528, 16'd3);
      add_csr(REG_ZERO_OFFSET, 16'hFFFF);                         // upper bits dropped
      add_csr(REG_GAIN, 16'hABFF);
      add_csr(REG_DEADBAND, 16'h0);
      add_adc(10'd0, 16'hFFFF);                                   // most negative current
      add_adc(10'd0, 16'd0);                                      // no elapsed time
      add_adc(10'd1, 16'd40000);
      add_csr(REG_ZERO_OFFSET, 16'h0);
      add_adc(10'd1023, 16'hFFFF);                                // most positive current
      add_adc(10'd512, 16'h8000);
      add_csr(REG_GAIN, 16'h0);
      add_adc(10'd1023, 16'd1);                                   // zero gain
      add_csr(REG_ZERO_OFFSET, 16'd526);
      add_csr(REG_GAIN, 16'hFF);
      add_csr(REG_DEADBAND, 16'hFFFF);                            // widest deadband
      add_adc(10'd1023, 16'd21845);
      add_adc(10'd600, 16'd5);
      add_adc(10'd341, 16'd10922);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            write_csr(directed_steps[i].index, directed_steps[i].value);
         else
            send_reading(directed_steps[i].adc, directed_steps[i].ms,
                         directed_steps[i].fixed, directed_steps[i].want);
      end
      settings_run++;

      // Random settings, two of them under a long receiver hold-off
      for (p = 0; p < RAND_PHASES; p++) random_phase(RAND_ITEMS, p == 1 || p == 5);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d sample transactions over %0d register settings (%0d writes),",
               items_sent, settings_run, csr_writes);
      $display("including deadband edges and long receiver stalls; %0d results, %0d bad.",
               readings_seen, mismatch_count);
      if (mismatch_count == 0 && expected_readings.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
